/* sv/pmt_pkg.sv */
// ----------------------------------------------------------------------------
// pmt_pkg: shared types for the 3D point stepper
// Command codes, sequencer states and the per-axis arithmetic lane opcodes.
// ----------------------------------------------------------------------------
package pmt_pkg;

    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_TOWARD = 2'd1,
        CMD_ALONG  = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIFF,
        S_LOAD,
        S_MUL,
        S_SUM,
        S_SQRT,
        S_CMP,
        S_MUL2,
        S_LDDIV,
        S_DIV,
        S_APPLY1,
        S_APPLY2,
        S_OUT
    } t_state;

    typedef enum logic [2:0] {
        LN_IDLE,
        LN_LOAD_MUL,
        LN_MUL,
        LN_LOAD_DIV,
        LN_DIV
    } t_lane_op;

    localparam logic [5:0] MUL_STEPS  = 6'd33;
    localparam logic [5:0] SQRT_STEPS = 6'd34;
    localparam logic [5:0] DIV_STEPS  = 6'd32;

endpackage

/* sv/point_move_toward_target_3d.sv */
// ----------------------------------------------------------------------------
// point_move_toward_target_3d: 3D position stepper in signed Q16.16
// Keeps one position; loads it, steps it toward a target or along a vector.
// ----------------------------------------------------------------------------
// Usage. Each input transaction on the s_axis channel carries a command in
// tuser and three coordinates plus a step length in tdata. Every input
// transaction yields exactly one output transaction on m_axis with the new
// position, the remaining distance and the arrived flag.
// Sequence. A load or the unused command passes through the difference and
// output states only. A step along a direction runs the 33-bit serial
// multiplier. A step toward a target runs a serial square and the 34-step
// square root when it arrives; when it does not, the serial square, the
// 34-step square root, a serial multiply and the 32-step restoring divide
// run one after another; the three axes run in parallel lanes. One item is
// worked on at a time.
// Stalls. The result sits in an output register; the next input transaction
// is taken while it waits, and the block holds its finished result until the
// receiver takes the previous one.
// Reset. A synchronous active-low reset clears the position to zero and
// empties the output register.
// ----------------------------------------------------------------------------
module point_move_toward_target_3d #(
    parameter int COORD_BITS = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // coord_x [31:0], coord_y [63:32], coord_z [95:64], step_length [127:96]
    input  logic [127:0] s_axis_tdata,
    // cmd [1:0]
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // pos_x [31:0], pos_y [63:32], pos_z [95:64], remaining [127:96]
    output logic [127:0] m_axis_tdata,
    // arrived [0]
    output logic [0:0]   m_axis_tuser
);
    import pmt_pkg::*;

    // Positions are stored at most 32 bits wide.
    localparam int POS_W = (COORD_BITS > 32) ? 32 : COORD_BITS;
    localparam logic signed [65:0] POS_MAX = (66'sd1 <<< (POS_W - 1)) - 66'sd1;
    localparam logic signed [65:0] POS_MIN = -POS_MAX - 66'sd1;
    localparam logic signed [36:0] REM_MAX = 37'sd2147483647;
    localparam logic signed [36:0] REM_MIN = -37'sd2147483648;

    function automatic logic signed [POS_W-1:0] f_sat(input logic signed [65:0] v);
        if (v > POS_MAX) begin
            return POS_MAX[POS_W-1:0];
        end else if (v < POS_MIN) begin
            return POS_MIN[POS_W-1:0];
        end
        return v[POS_W-1:0];
    endfunction

    t_state r_state, n_state;
    logic [5:0] r_cnt, n_cnt;
    t_cmd r_cmd, n_cmd;
    logic signed [31:0] r_c [3];
    logic signed [31:0] n_c [3];
    logic signed [31:0] r_dist, n_dist;
    logic [32:0] r_am [3];
    logic [32:0] n_am [3];
    logic [2:0] r_dneg, n_dneg;
    logic signed [POS_W-1:0] r_pos [3];
    logic signed [POS_W-1:0] n_pos [3];
    logic signed [31:0] r_rem, n_rem;
    logic r_arr, n_arr;
    logic [67:0] r_rad, n_rad;
    logic [35:0] r_srem, n_srem;
    logic [33:0] r_root, n_root;
    logic r_mvalid, n_mvalid;
    logic [127:0] r_mdata, n_mdata;
    logic r_muser, n_muser;

    t_lane_op lane_op;
    logic [32:0] lane_b;
    logic [32:0] dm;
    logic [65:0] prod [3];
    logic [31:0] quot [3];

    logic signed [32:0] diff;
    logic [37:0] sq_x, sq_t;
    logic sq_ge;
    logic signed [65:0] pw, dv, rnd;
    logic signed [36:0] rdiff;
    logic take;

    assign dm = r_dist[31] ? 33'(-{r_dist[31], r_dist}) : {1'b0, r_dist};
    assign lane_b = (r_state == S_LOAD && r_cmd == CMD_TOWARD) ? 33'd0 : dm;

    genvar g;
    generate
        for (g = 0; g < 3; g++) begin : g_lane
            pmt_lane u_lane (
                .i_clk  (i_clk),
                .i_op   (lane_op),
                .i_a    (r_am[g]),
                .i_b    ((r_state == S_LOAD && r_cmd == CMD_TOWARD) ? r_am[g] : lane_b),
                .i_len  (r_root),
                .o_prod (prod[g]),
                .o_quot (quot[g])
            );
        end
    endgenerate

    assign s_axis_tready = (r_state == S_IDLE);
    assign take = s_axis_tvalid && (r_state == S_IDLE);

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_cmd    = r_cmd;
        n_c      = r_c;
        n_dist   = r_dist;
        n_am     = r_am;
        n_dneg   = r_dneg;
        n_pos    = r_pos;
        n_rem    = r_rem;
        n_arr    = r_arr;
        n_rad    = r_rad;
        n_srem   = r_srem;
        n_root   = r_root;
        n_mvalid = r_mvalid;
        n_mdata  = r_mdata;
        n_muser  = r_muser;
        lane_op  = LN_IDLE;
        diff     = '0;
        pw       = '0;
        dv       = '0;
        rnd      = '0;
        sq_x     = {r_srem, r_rad[67:66]};
        sq_t     = {2'b00, r_root, 2'b01};
        sq_ge    = (sq_x >= sq_t);
        rdiff    = $signed({3'b000, r_root}) - 37'(r_dist);

        if (m_axis_tready) begin
            n_mvalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (take) begin
                    n_cmd   = t_cmd'(s_axis_tuser);
                    n_c[0]  = s_axis_tdata[31:0];
                    n_c[1]  = s_axis_tdata[63:32];
                    n_c[2]  = s_axis_tdata[95:64];
                    n_dist  = s_axis_tdata[127:96];
                    n_rem   = '0;
                    n_arr   = 1'b0;
                    n_state = S_DIFF;
                end
            end
            S_DIFF: begin
                for (int k = 0; k < 3; k++) begin
                    if (r_cmd == CMD_ALONG) begin
                        // Direction magnitude and sign, combined with the step sign.
                        n_am[k]   = r_c[k][31] ? 33'(-{r_c[k][31], r_c[k]})
                                               : {1'b0, r_c[k]};
                        n_dneg[k] = r_c[k][31] ^ r_dist[31];
                    end else begin
                        diff      = 33'(r_c[k]) - 33'(r_pos[k]);
                        n_am[k]   = diff[32] ? 33'(-diff) : diff;
                        n_dneg[k] = diff[32] ^ r_dist[31];
                    end
                end
                case (r_cmd)
                    CMD_LOAD: begin
                        for (int k = 0; k < 3; k++) begin
                            n_pos[k] = f_sat(66'(r_c[k]));
                        end
                        n_state = S_OUT;
                    end
                    CMD_TOWARD, CMD_ALONG: begin
                        n_state = S_LOAD;
                    end
                    default: begin
                        n_state = S_OUT;
                    end
                endcase
            end
            S_LOAD: begin
                lane_op = LN_LOAD_MUL;
                n_cnt   = '0;
                n_state = S_MUL;
            end
            S_MUL: begin
                lane_op = LN_MUL;
                n_cnt   = r_cnt + 6'd1;
                if (r_cnt == MUL_STEPS - 6'd1) begin
                    n_cnt   = '0;
                    n_state = (r_cmd == CMD_ALONG) ? S_APPLY2 : S_SUM;
                end
            end
            S_SUM: begin
                n_rad   = {2'b00, prod[0] + prod[1] + prod[2]};
                n_srem  = '0;
                n_root  = '0;
                n_cnt   = '0;
                n_state = S_SQRT;
            end
            S_SQRT: begin
                // One root bit per cycle from two radicand bits.
                n_srem  = sq_ge ? 36'(sq_x - sq_t) : sq_x[35:0];
                n_root  = {r_root[32:0], sq_ge};
                n_rad   = {r_rad[65:0], 2'b00};
                n_cnt   = r_cnt + 6'd1;
                if (r_cnt == SQRT_STEPS - 6'd1) begin
                    n_cnt   = '0;
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (r_root == '0 || $signed(35'(r_dist)) >= $signed({1'b0, r_root})) begin
                    for (int k = 0; k < 3; k++) begin
                        n_pos[k] = f_sat(66'(r_c[k]));
                    end
                    n_arr   = 1'b1;
                    n_state = S_OUT;
                end else begin
                    lane_op = LN_LOAD_MUL;
                    n_cnt   = '0;
                    n_state = S_MUL2;
                end
            end
            S_MUL2: begin
                lane_op = LN_MUL;
                n_cnt   = r_cnt + 6'd1;
                if (r_cnt == MUL_STEPS - 6'd1) begin
                    n_cnt   = '0;
                    n_state = S_LDDIV;
                end
            end
            S_LDDIV: begin
                lane_op = LN_LOAD_DIV;
                n_cnt   = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                lane_op = LN_DIV;
                n_cnt   = r_cnt + 6'd1;
                if (r_cnt == DIV_STEPS - 6'd1) begin
                    n_cnt   = '0;
                    n_state = S_APPLY1;
                end
            end
            S_APPLY1: begin
                for (int k = 0; k < 3; k++) begin
                    dv       = r_dneg[k] ? -66'(quot[k]) : 66'(quot[k]);
                    pw       = 66'(r_pos[k]);
                    n_pos[k] = f_sat(pw + dv);
                end
                if (rdiff > REM_MAX) begin
                    n_rem = REM_MAX[31:0];
                end else if (rdiff < REM_MIN) begin
                    n_rem = REM_MIN[31:0];
                end else begin
                    n_rem = rdiff[31:0];
                end
                n_state = S_OUT;
            end
            S_APPLY2: begin
                // Round half toward plus infinity, then drop the 16 fraction bits.
                for (int k = 0; k < 3; k++) begin
                    rnd      = (r_dneg[k] ? -66'(prod[k][63:0]) : 66'(prod[k][63:0]))
                               + 66'sd32768;
                    dv       = rnd >>> 16;
                    pw       = 66'(r_pos[k]);
                    n_pos[k] = f_sat(pw + dv);
                end
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_mvalid || m_axis_tready) begin
                    n_mvalid = 1'b1;
                    n_mdata  = {r_rem, 32'(r_pos[2]), 32'(r_pos[1]), 32'(r_pos[0])};
                    n_muser  = r_arr;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_mvalid <= 1'b0;
            for (int k = 0; k < 3; k++) begin
                r_pos[k] <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_mvalid <= n_mvalid;
            r_pos    <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_c     <= n_c;
        r_dist  <= n_dist;
        r_am    <= n_am;
        r_dneg  <= n_dneg;
        r_rem   <= n_rem;
        r_arr   <= n_arr;
        r_rad   <= n_rad;
        r_srem  <= n_srem;
        r_root  <= n_root;
        r_mdata <= n_mdata;
        r_muser <= n_muser;
    end

    assign m_axis_tvalid   = r_mvalid;
    assign m_axis_tdata    = r_mdata;
    assign m_axis_tuser[0] = r_muser;

endmodule

/* sv/pmt_lane.sv */
// ----------------------------------------------------------------------------
// pmt_lane: bit-serial multiply and rounded divide for one axis
// Shift-add multiplier (one multiplier bit per cycle) and restoring divider
// (one quotient bit per cycle) that divides the product in the multiplier's accumulator.
// ----------------------------------------------------------------------------
module pmt_lane (
    input  logic              i_clk,
    input  pmt_pkg::t_lane_op i_op,
    input  logic [32:0]       i_a,
    input  logic [32:0]       i_b,
    input  logic [33:0]       i_len,
    output logic [65:0]       o_prod,
    output logic [31:0]       o_quot
);
    import pmt_pkg::*;

    logic [32:0] r_a, n_a;
    logic [65:0] r_acc, n_acc;
    logic [33:0] r_rem, n_rem;
    logic [31:0] r_q, n_q;
    logic [33:0] sum;
    logic [64:0] num;
    logic [34:0] trial;
    logic        ge;

    always_comb begin
        n_a   = r_a;
        n_acc = r_acc;
        n_rem = r_rem;
        n_q   = r_q;
        sum   = {1'b0, r_acc[65:33]} + (r_acc[0] ? {1'b0, r_a} : 34'd0);
        num   = {1'b0, r_acc[63:0]} + {32'd0, i_len[33:1]};
        trial = {r_rem, r_q[31]};
        ge    = (trial >= {1'b0, i_len});
        case (i_op)
            LN_LOAD_MUL: begin
                n_a   = i_a;
                n_acc = {33'd0, i_b};
            end
            LN_MUL: begin
                n_acc = {sum, r_acc[32:1]};
            end
            LN_LOAD_DIV: begin
                // The quotient fits 32 bits, so the top part is below the divisor.
                n_rem = {1'b0, num[64:32]};
                n_q   = num[31:0];
            end
            LN_DIV: begin
                n_rem = ge ? 34'(trial - {1'b0, i_len}) : trial[33:0];
                n_q   = {r_q[30:0], ge};
            end
            default: begin
                n_a = r_a;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_a   <= n_a;
        r_acc <= n_acc;
        r_rem <= n_rem;
        r_q   <= n_q;
    end

    assign o_prod = r_acc;
    assign o_quot = r_q;

endmodule

/* bench/pmt_checker.sv */
// ----------------------------------------------------------------------------
// pmt_checker: result checker for the 3D point stepper
// Watches both stream channels, predicts each result from accepted commands
// and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module pmt_checker
    import pmt_pkg::*;
#(
    parameter int COORD_BITS = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    input  logic         i_in_ready,
    input  logic [127:0] i_in_data,
    input  logic [1:0]   i_in_user,
    input  logic         i_out_valid,
    input  logic         i_out_ready,
    input  logic [127:0] i_out_data,
    input  logic [0:0]   i_out_user,
    output int           o_fail_count,
    output int           o_pending
);

    localparam int PB = (COORD_BITS > 32) ? 32 : ((COORD_BITS < 2) ? 2 : COORD_BITS);
    localparam longint PMAX = (64'sd1 <<< (PB - 1)) - 1;
    localparam longint PMIN = -PMAX - 1;

    typedef struct packed {
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] pz;
        logic [31:0] rem;
        logic        arrived;
    } t_move_result;

    t_move_result expected_moves[$];
    longint       cur_pos[3];
    int           n_fail;

    assign o_fail_count = n_fail;
    assign o_pending    = expected_moves.size();

    function automatic longint sat(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Bitwise floor square root of an unsigned sum below 2^68.
    function automatic logic [33:0] floor_sqrt(logic [67:0] s);
        logic [33:0] r;
        logic [33:0] t;
        r = '0;
        for (int b = 33; b >= 0; b--) begin
            t = r | (34'd1 << b);
            if ({34'd0, t} * {34'd0, t} <= s) r = t;
        end
        return r;
    endfunction

    // Advances the tracked position by one command and returns the result.
    function automatic t_move_result apply_move(t_cmd cmd, logic [127:0] d);
        t_move_result res;
        longint       c[3];
        longint       dl[3];
        longint       step_len;
        longint       rem;
        logic [67:0]  sumsq;
        logic [33:0]  len;
        logic [127:0] q;
        longint       r;
        longint       delta;
        logic         neg;
        rem = 0;
        res.arrived = 1'b0;
        step_len = longint'($signed(d[127:96]));
        for (int i = 0; i < 3; i++) c[i] = longint'($signed(d[32*i +: 32]));
        case (cmd)
            CMD_LOAD: begin
                for (int i = 0; i < 3; i++) cur_pos[i] = sat(c[i], PMIN, PMAX);
            end
            CMD_TOWARD: begin
                sumsq = '0;
                for (int i = 0; i < 3; i++) begin
                    dl[i] = c[i] - cur_pos[i];
                    sumsq += 68'(dl[i] < 0 ? -dl[i] : dl[i]) * 68'(dl[i] < 0 ? -dl[i] : dl[i]);
                end
                len = floor_sqrt(sumsq);
                if (len == 0 || step_len >= longint'(len)) begin
                    for (int i = 0; i < 3; i++) cur_pos[i] = sat(c[i], PMIN, PMAX);
                    res.arrived = 1'b1;
                end else begin
                    for (int i = 0; i < 3; i++) begin
                        neg = (step_len < 0) != (dl[i] < 0);
                        q = (128'(step_len < 0 ? -step_len : step_len)
                             * 128'(dl[i] < 0 ? -dl[i] : dl[i])
                             + 128'(len >> 1)) / 128'(len);
                        delta = neg ? -longint'(q) : longint'(q);
                        cur_pos[i] = sat(cur_pos[i] + delta, PMIN, PMAX);
                    end
                    rem = sat(longint'(len) - step_len, -64'sd2147483648, 64'sd2147483647);
                end
            end
            CMD_ALONG: begin
                for (int i = 0; i < 3; i++) begin
                    r = step_len * c[i] + 32768;
                    delta = (r >= 0) ? r / 65536 : -((-r + 65535) / 65536);
                    cur_pos[i] = sat(cur_pos[i] + delta, PMIN, PMAX);
                end
            end
            default: ;
        endcase
        res.px  = cur_pos[0][31:0];
        res.py  = cur_pos[1][31:0];
        res.pz  = cur_pos[2][31:0];
        res.rem = rem[31:0];
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
        n_fail++;
    endtask

    initial begin
        n_fail = 0;
        for (int i = 0; i < 3; i++) cur_pos[i] = 0;
    end

    always @(posedge i_clk) begin
        t_move_result want;
        if (i_rst_n && i_out_valid && i_out_ready) begin
            if (expected_moves.size() == 0) begin
                report_mismatch("result with none expected", i_out_data[31:0], 32'd0);
            end else begin
                want = expected_moves.pop_front();
                if (i_out_data[31:0] !== want.px) report_mismatch("pos_x", i_out_data[31:0], want.px);
                if (i_out_data[63:32] !== want.py) report_mismatch("pos_y", i_out_data[63:32], want.py);
                if (i_out_data[95:64] !== want.pz) report_mismatch("pos_z", i_out_data[95:64], want.pz);
                if (i_out_data[127:96] !== want.rem)
                    report_mismatch("remaining", i_out_data[127:96], want.rem);
                if (i_out_user[0] !== want.arrived)
                    report_mismatch("arrived", {31'd0, i_out_user[0]}, {31'd0, want.arrived});
            end
        end
        if (i_rst_n && i_in_valid && i_in_ready)
            expected_moves.push_back(apply_move(t_cmd'(i_in_user), i_in_data));
    end

endmodule

/* bench/tb_point_move_toward_target_3d.sv */
// ----------------------------------------------------------------------------
// tb_point_move_toward_target_3d: testbench for the 3D point stepper
// Drives directed and random commands with random idle bursts on both sides;
// the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_point_move_toward_target_3d;
    import pmt_pkg::*;

    localparam int  N_RANDOM    = 1880;
    localparam int  QUIET_ITEMS = 200;
    // The limit covers the worst-case block time plus a receiver stall burst per
    // item, plus the long hold-off, many times over.
    localparam longint CYCLE_LIMIT = 1500000;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    // coord_x [31:0], coord_y [63:32], coord_z [95:64], step_length [127:96]
    logic [127:0] s_axis_tdata;
    // cmd [1:0]
    logic [1:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    // pos_x [31:0], pos_y [63:32], pos_z [95:64], remaining [127:96]
    logic [127:0] m_axis_tdata;
    // arrived [0]
    logic [0:0]   m_axis_tuser;

    int     fail_count;
    int     pending;
    longint cycle_count;
    int     items_sent;
    logic   quiet;       // no idling in the final stretch
    logic   hold_off;    // receiver holds off for a long stretch

    point_move_toward_target_3d u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    pmt_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_in_user    (s_axis_tuser),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .i_out_user   (m_axis_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_point_move_toward_target_3d failed");
            $finish;
        end
    end

    // Random coordinate with a bias toward the edges and small magnitudes,
    // which keeps most steps short enough to stay in range.
    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'(0);
            3, 4: return $urandom;
            default: return 32'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
        endcase
    endfunction

    // Sends one transaction and waits for it to be accepted, with an
    // optional idle burst before it.
    task automatic send_move(t_cmd cmd, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                             logic [31:0] step_len);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {step_len, z, y, x};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        items_sent++;
    endtask

    // Receiver: random stall bursts, plus one long hold-off on request.
    initial begin
        m_axis_tready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_off) begin
                m_axis_tready <= 1'b0;
                repeat (600) @(posedge i_clk);
                hold_off = 1'b0;
            end else if (!quiet && $urandom_range(0, 4) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    initial begin
        t_cmd cmd;
        int   w;
        cycle_count   = 0;
        items_sent    = 0;
        quiet         = 1'b0;
        hold_off      = 1'b0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = CMD_LOAD;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: extremes, every command, arrival, tiny distance,
        // negative step and the unused command.
        send_move(CMD_NONE, 32'h1, 32'h2, 32'h3, 32'h4);
        send_move(CMD_TOWARD, 32'h0, 32'h0, 32'h0, 32'h0);
        send_move(CMD_TOWARD, 32'h0, 32'h0, 32'h1, 32'h0);
        send_move(CMD_LOAD, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0);
        send_move(CMD_TOWARD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0001_0000);
        send_move(CMD_TOWARD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        send_move(CMD_TOWARD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_move(CMD_ALONG, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 32'h7FFF_FFFF);
        send_move(CMD_ALONG, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_0000, 32'h8000_0000);
        send_move(CMD_LOAD, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF);
        send_move(CMD_ALONG, 32'h0000_8000, 32'hFFFF_8000, 32'h0000_0001, 32'h0000_0001);
        send_move(CMD_TOWARD, 32'h0003_0000, 32'h0004_0000, 32'h0, 32'h0001_0000);
        send_move(CMD_TOWARD, 32'h0003_0000, 32'h0004_0000, 32'h0, 32'hFFFF_0000);
        send_move(CMD_TOWARD, 32'h0003_0000, 32'h0004_0000, 32'h0, 32'h0010_0000);
        send_move(CMD_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_move(CMD_ALONG, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

        // Sender pauses until every result is back.
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);

        // Random part; about a third of the way in, the receiver holds off
        // while items keep coming, so the block fills and stalls its input.
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM / 3) hold_off = 1'b1;
            if (n == N_RANDOM - QUIET_ITEMS) quiet = 1'b1;
            w = $urandom_range(0, 19);
            cmd = (w < 4) ? CMD_LOAD : (w < 13) ? CMD_TOWARD : (w < 19) ? CMD_ALONG : CMD_NONE;
            send_move(cmd, pick_coord(), pick_coord(), pick_coord(),
                      ($urandom_range(0, 3) == 0) ? $urandom : pick_coord());
        end
        s_axis_tvalid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb_point_move_toward_target_3d passed");
        end else begin
            $display("tb_point_move_toward_target_3d failed");
        end
        $finish;
    end

endmodule
